// ----- design/assert_macros.svh -----
// Assertion macros used by the page allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i and disabled in reset.
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i and disabled in reset.
`define PAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PAL_ASSERT_IMP(lbl, ante, cons, msg)
`define PAL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/pal_pkg.sv -----
// Shared constants, codes and control types of the page allocator.
`default_nettype none
package pal_pkg;

  // Default geometry of the managed page pool.
  localparam int unsigned DEF_NUM_PAGES  = 32768;
  localparam int unsigned DEF_PAGE_SHIFT = 12;
  localparam logic [31:0] DEF_BASE_ADDR  = 32'h8000_0000;

  // Reset value of the lowest usable address register.
  localparam logic [31:0] CFG_RESET = 32'h8000_0000;

  // Saturation value of a reference count.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_ADDREF = 2'd2;
  localparam logic [1:0] OP_SEED   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BADADDR = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_NOTONE  = 3'd4;
  localparam logic [2:0] ST_OVER    = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // zero one count entry of the clearing sweep
    logic accept;  // take the input word and start the memory reads
    logic pop;     // read the count of the page on top of the stack
    logic exec;    // update the memories and load the result
  } pal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_alloc;     // the word at the input is an allocate
    logic stack_empty;  // no page on the free stack
    logic clear_last;   // the sweep is at its last entry
  } pal_sts_t;

endpackage
`default_nettype wire

// ----- design/page_allocator_refcount.sv -----
// A word is accepted in idle, which registers its count memory read; an allocate that finds a
// page on the stack first passes the pop state, reading the count at the popped stack index.
// The execute state then loads the result, whose strobe is registered. A new word waits for idle.
// The next word is accepted in the cycle its predecessor's result shows; the receiver cannot stall.
// Reset: asynchronous, active low; a clearing sweep then zeroes every count, one entry a cycle,
// with busy high; configuration writes are taken at any time.
`default_nettype none
module page_allocator_refcount #(
  parameter int unsigned NUM_PAGES  = pal_pkg::DEF_NUM_PAGES,
  parameter int unsigned PAGE_SHIFT = pal_pkg::DEF_PAGE_SHIFT,
  parameter logic [31:0] BASE_ADDR  = pal_pkg::DEF_BASE_ADDR
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] page_addr_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [31:0]      alloc_addr_o,
  output logic [15:0]      new_count_o,
  output logic             page_released_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  pal_pkg::pal_cmd_t cmd;
  pal_pkg::pal_sts_t sts;

  // The address register takes a word in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencing of each operation.
  pal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Memories, checks and result registers.
  pal_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .BASE_ADDR  (BASE_ADDR)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .page_addr_i     (page_addr_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .alloc_addr_o    (alloc_addr_o),
    .new_count_o     (new_count_o),
    .page_released_o (page_released_o)
  );

endmodule
`default_nettype wire

// ----- design/pal_ctrl.sv -----
// Controller state machine of the page allocator.
`default_nettype none
module pal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pal_pkg::pal_sts_t sts_i,
  output pal_pkg::pal_cmd_t      cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_POP   = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.accept = start;
        if (start) begin
          // An allocate needs the popped index before its count can be read.
          if (sts_i.in_alloc && !sts_i.stack_empty) begin
            state_d = S_POP;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- design/pal_datapath.sv -----
// Datapath of the page allocator: count and stack memories, checks and result.
`default_nettype none
`include "assert_macros.svh"
module pal_datapath #(
  parameter int unsigned NUM_PAGES  = pal_pkg::DEF_NUM_PAGES,
  parameter int unsigned PAGE_SHIFT = pal_pkg::DEF_PAGE_SHIFT,
  parameter logic [31:0] BASE_ADDR  = pal_pkg::DEF_BASE_ADDR
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pal_pkg::pal_cmd_t cmd_i,
  output pal_pkg::pal_sts_t      sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [31:0]       page_addr_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic [31:0]            alloc_addr_o,
  output logic [15:0]            new_count_o,
  output logic                   page_released_o
);

  localparam int unsigned IDX_W       = $clog2(NUM_PAGES);
  localparam int unsigned TOP_W       = IDX_W + 1;
  localparam logic [31:0] PAGES_32    = 32'(NUM_PAGES);
  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PAGES - 1);

  // Memories.
  logic [15:0]      cnt_mem [NUM_PAGES];
  logic [IDX_W-1:0] stk_mem [NUM_PAGES];

  // Registers.
  logic [31:0]      first_usable_q;
  logic [1:0]       op_q;
  logic             bad_q;
  logic [IDX_W-1:0] idx_q;
  logic [TOP_W-1:0] top_q;
  logic [TOP_W-1:0] top_d;
  logic [IDX_W-1:0] clr_idx_q;
  logic [IDX_W-1:0] stk_rd_q;
  logic [15:0]      cnt_rd_q;
  logic             valid_q;
  logic [2:0]       status_q;
  logic [31:0]      addr_q;
  logic [15:0]      count_q;
  logic             rel_q;

  // Address check and index of the incoming word.
  logic [32:0]      off;
  logic             aligned;
  logic             ge_first;
  logic             in_range;
  logic             in_bad;
  logic [IDX_W-1:0] in_idx;

  // Memory port control.
  logic [IDX_W-1:0] cnt_ra;
  logic [IDX_W-1:0] cnt_wa;
  logic [15:0]      cnt_wd;
  logic             cnt_we;
  logic             cnt_re;
  logic [IDX_W-1:0] stk_ra;
  logic [TOP_W-1:0] top_m1;
  logic             stk_we;

  // Result of the operation in the execute cycle.
  logic [2:0]  res_status;
  logic [31:0] res_addr;
  logic [15:0] res_count;
  logic        res_rel;
  logic        exec_we;
  logic [15:0] exec_wd;
  logic        exec_push;
  logic        full;

  assign off      = {1'b0, page_addr_i} - {1'b0, BASE_ADDR};
  assign aligned  = (page_addr_i[PAGE_SHIFT-1:0] == '0);
  assign ge_first = (page_addr_i >= first_usable_q);
  assign in_range = !off[32] && ((off[31:0] >> PAGE_SHIFT) < PAGES_32);
  assign in_bad   = !(aligned && ge_first && in_range);
  assign in_idx   = IDX_W'(off[31:0] >> PAGE_SHIFT);

  assign full   = (top_q == TOP_FULL);
  assign top_m1 = top_q - TOP_W'(1);
  assign stk_ra = top_m1[IDX_W-1:0];

  assign sts_o.in_alloc    = (opcode_i == pal_pkg::OP_ALLOC);
  assign sts_o.stack_empty = (top_q == '0);
  assign sts_o.clear_last  = (clr_idx_q == IDX_LAST);

  // Operation on the fetched count.
  always_comb begin
    res_status = pal_pkg::ST_OK;
    res_addr   = '0;
    res_count  = '0;
    res_rel    = 1'b0;
    exec_we    = 1'b0;
    exec_wd    = '0;
    exec_push  = 1'b0;
    top_d      = top_q;
    if (op_q == pal_pkg::OP_ALLOC) begin
      if (top_q == '0) begin
        res_status = pal_pkg::ST_EMPTY;
      end else if (cnt_rd_q != '0) begin
        res_status = pal_pkg::ST_NOTONE;
        res_count  = cnt_rd_q;
      end else begin
        top_d     = top_m1;
        exec_we   = 1'b1;
        exec_wd   = 16'd1;
        res_count = 16'd1;
        res_addr  = BASE_ADDR + (32'(idx_q) << PAGE_SHIFT);
      end
    end else if (bad_q) begin
      res_status = pal_pkg::ST_BADADDR;
    end else begin
      case (op_q)
        pal_pkg::OP_FREE: begin
          if (cnt_rd_q == '0) begin
            res_status = pal_pkg::ST_UNDER;
          end else if (cnt_rd_q == 16'd1) begin
            if (full) begin
              res_status = pal_pkg::ST_FULL;
              res_count  = 16'd1;
            end else begin
              exec_we   = 1'b1;
              exec_push = 1'b1;
              top_d     = top_q + TOP_W'(1);
              res_rel   = 1'b1;
            end
          end else begin
            exec_we   = 1'b1;
            exec_wd   = cnt_rd_q - 16'd1;
            res_count = cnt_rd_q - 16'd1;
          end
        end
        pal_pkg::OP_ADDREF: begin
          if (cnt_rd_q == pal_pkg::COUNT_MAX) begin
            res_status = pal_pkg::ST_OVER;
            res_count  = pal_pkg::COUNT_MAX;
          end else begin
            exec_we   = 1'b1;
            exec_wd   = cnt_rd_q + 16'd1;
            res_count = cnt_rd_q + 16'd1;
          end
        end
        pal_pkg::OP_SEED: begin
          // Seed overwrites the count with zero and frees it straight away.
          if (full) begin
            res_status = pal_pkg::ST_FULL;
            res_count  = cnt_rd_q;
          end else begin
            exec_we   = 1'b1;
            exec_push = 1'b1;
            top_d     = top_q + TOP_W'(1);
            res_rel   = 1'b1;
          end
        end
        default: begin
          res_status = pal_pkg::ST_OK;
        end
      endcase
    end
  end

  // Port selection of the count memory: sweep, execute write, fetch read.
  assign cnt_wa = cmd_i.clear ? clr_idx_q : idx_q;
  assign cnt_wd = cmd_i.clear ? 16'd0 : exec_wd;
  assign cnt_we = cmd_i.clear || (cmd_i.exec && exec_we);
  assign cnt_ra = cmd_i.pop ? stk_rd_q : in_idx;
  assign cnt_re = cmd_i.accept || cmd_i.pop;
  assign stk_we = cmd_i.exec && exec_push;

  // Reference count memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_ra];
    end
  end

  // Free stack memory; the top entry is read when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[top_q[IDX_W-1:0]] <= idx_q;
    end
    if (cmd_i.accept) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  // Operand registers of the word in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= opcode_i;
      bad_q <= in_bad;
      idx_q <= in_idx;
    end else if (cmd_i.pop) begin
      idx_q <= stk_rd_q;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= res_status;
      addr_q   <= res_addr;
      count_q  <= res_count;
      rel_q    <= res_rel;
    end
  end

  // Control state: stack top, sweep index, configuration, result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q          <= '0;
      clr_idx_q      <= '0;
      first_usable_q <= pal_pkg::CFG_RESET;
      valid_q        <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        top_q <= top_d;
      end
      if (cmd_i.clear) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      if (cfg_we_i) begin
        first_usable_q <= cfg_data_i;
      end
      valid_q <= cmd_i.exec;
    end
  end

  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign alloc_addr_o    = addr_q;
  assign new_count_o     = count_q;
  assign page_released_o = rel_q;

  // The stack pointer never passes the pool size.
  `PAL_ASSERT_IMP(a_top_bound, 1'b1, top_q <= TOP_FULL, "free stack top beyond pool size")
  // A push only happens with room on the stack.
  `PAL_ASSERT_IMP(a_push_room, stk_we, !full, "push onto a full free stack")
  // A released page grows the stack by exactly one.
  `PAL_ASSERT_NXT(a_rel_push, cmd_i.exec && res_rel, top_q == $past(top_q) + TOP_W'(1), "release without push")
  // The clearing sweep never overlaps a stack write or an accepted word.
  `PAL_ASSERT_IMP(a_clear_quiet, cmd_i.clear, !stk_we && !cmd_i.accept, "activity during clearing sweep")

endmodule
`default_nettype wire
